### hdl/sexs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and byte-class functions for the s-expression token scanner.
// No dependencies; imported by every module of the block.
package sexs_pkg;

	// Default configuration of the scanner.
	localparam int MAX_DEPTH_DEF = 255;
	localparam int LINE_BITS_DEF = 16;
	localparam int COL_BITS_DEF  = 12;

	// Fixed widths of the result fields on the output stream.
	localparam int DEPTH_OUT_W = 8;
	localparam int LINE_OUT_W  = 16;
	localparam int COL_OUT_W   = 12;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 48;

	// Byte constants.
	localparam logic [7:0] CH_BACKQ  = 8'h60;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// Scanner modes.
	typedef enum logic [2:0] {
		M_OUT   = 3'd0,
		M_LIST  = 3'd1,
		M_IDENT = 3'd2,
		M_RAW   = 3'd3,
		M_STR   = 3'd4,
		M_CMT   = 3'd5
	} mode_t;

	// Role of a byte.
	typedef enum logic [3:0] {
		K_SKIP       = 4'd0,
		K_OPEN       = 4'd1,
		K_CLOSE      = 4'd2,
		K_CLOSE_ALL  = 4'd3,
		K_IDENT_START = 4'd4,
		K_IDENT_CONT = 4'd5,
		K_RAW_QUOTE  = 4'd6,
		K_RAW_CHAR   = 4'd7,
		K_STR_QUOTE  = 4'd8,
		K_STR_CHAR   = 4'd9,
		K_CMT_START  = 4'd10,
		K_CMT_CHAR   = 4'd11
	} kind_t;

	// Error codes.
	typedef enum logic [2:0] {
		E_NONE        = 3'd0,
		E_EXPECT_OPEN = 3'd1,
		E_BAD_LIST    = 3'd2,
		E_NL_IN_STR   = 3'd3,
		E_DEPTH_OVF   = 3'd4
	} err_t;

	// Per-byte flags handed from the classifier to the result register.
	typedef struct packed {
		kind_t kind;
		logic  ends_token;
		err_t  error_code;
		logic  form_done;
	} scan_flags_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER);
	endfunction

endpackage

### hdl/sexs_classify.sv
`timescale 1ns / 1ps
// Combinational byte classifier: mode and depth transition for one source byte.
// Depends on sexs_pkg.
module sexs_classify import sexs_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF,
	parameter int DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
	input  logic [7:0]         ch,
	input  mode_t              mode,
	input  logic [DEPTH_W-1:0] depth,
	output mode_t              mode_next,
	output logic [DEPTH_W-1:0] depth_next,
	output scan_flags_t        flags
);

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

	logic depth_full;
	logic depth_zero;
	logic list_path;

	assign depth_full = (depth == DEPTH_MAX);
	assign depth_zero = (depth == '0);

	// Mode-specific handling, then the shared list rules when the byte falls through.
	always_comb begin
		flags      = '{kind: K_SKIP, ends_token: 1'b0, error_code: E_NONE, form_done: 1'b0};
		mode_next  = mode;
		depth_next = depth;
		list_path  = 1'b0;

		case (mode)
			M_LIST: begin
				list_path = 1'b1;
			end
			M_IDENT: begin
				if (is_word(ch)) begin
					flags.kind = K_IDENT_CONT;
				end else begin
					flags.ends_token = 1'b1;
					list_path        = 1'b1;
				end
			end
			M_RAW: begin
				if (ch == CH_BACKQ) begin
					flags.kind       = K_RAW_QUOTE;
					flags.ends_token = 1'b1;
					mode_next        = M_LIST;
				end else begin
					flags.kind = K_RAW_CHAR;
				end
			end
			M_STR: begin
				if (ch == CH_DQUOTE) begin
					flags.kind       = K_STR_QUOTE;
					flags.ends_token = 1'b1;
					mode_next        = M_LIST;
				end else if (ch == CH_NL) begin
					flags.ends_token = 1'b1;
					flags.error_code = E_NL_IN_STR;
					mode_next        = M_LIST;
				end else begin
					flags.kind = K_STR_CHAR;
				end
			end
			M_CMT: begin
				if (ch == CH_NL) begin
					flags.ends_token = 1'b1;
					mode_next        = M_LIST;
				end else begin
					flags.kind = K_CMT_CHAR;
				end
			end
			default: begin
				// Top level: only an open paren or whitespace is legal.
				mode_next = M_OUT;
				if (ch == CH_LPAREN) begin
					flags.kind = K_OPEN;
					mode_next  = M_LIST;
					if (depth_full) begin
						flags.error_code = E_DEPTH_OVF;
					end else begin
						depth_next = depth + 1'b1;
					end
				end else if (!is_ws(ch)) begin
					flags.error_code = E_EXPECT_OPEN;
				end
			end
		endcase

		// List rules, also reached by the byte that ends an identifier.
		if (list_path) begin
			mode_next = M_LIST;
			if (is_ws(ch)) begin
				flags.kind = K_SKIP;
			end else if (is_letter(ch) || (ch == CH_UNDER)) begin
				flags.kind = K_IDENT_START;
				mode_next  = M_IDENT;
			end else if (ch == CH_BACKQ) begin
				flags.kind = K_RAW_QUOTE;
				mode_next  = M_RAW;
			end else if (ch == CH_DQUOTE) begin
				flags.kind = K_STR_QUOTE;
				mode_next  = M_STR;
			end else if (ch == CH_SEMI) begin
				flags.kind = K_CMT_START;
				mode_next  = M_CMT;
			end else if (ch == CH_LPAREN) begin
				flags.kind = K_OPEN;
				if (depth_full) begin
					flags.error_code = E_DEPTH_OVF;
				end else begin
					depth_next = depth + 1'b1;
				end
			end else if (ch == CH_RPAREN) begin
				if (depth_zero) begin
					flags.error_code = E_BAD_LIST;
					mode_next        = M_OUT;
				end else begin
					flags.kind = K_CLOSE;
					depth_next = depth - 1'b1;
					if (depth == DEPTH_W'(1)) begin
						flags.form_done = 1'b1;
						mode_next       = M_OUT;
					end
				end
			end else if (ch == CH_RBRACK) begin
				flags.kind      = K_CLOSE_ALL;
				depth_next      = '0;
				flags.form_done = 1'b1;
				mode_next       = M_OUT;
			end else begin
				flags.kind       = K_SKIP;
				flags.error_code = E_BAD_LIST;
			end
		end
	end

endmodule

### hdl/sexpr_token_scanner.sv
`timescale 1ns / 1ps
// S-expression token scanner top level: input register, classifier, position
// counters and result register. Depends on sexs_pkg and sexs_classify.
//
// Usage:
//   The slave stream (s_tvalid, s_tready, s_tdata) carries one source byte per
//   item. The master stream (m_tvalid, m_tready, m_tdata) carries exactly one
//   result item per byte, in order: role of the byte, token end flag, error
//   code, nesting depth after the byte, form complete flag, line and column.
//   A byte is first captured in the input register; the classifier and the
//   position counters then work on it and the result is loaded into the output
//   register. One item per cycle is sustained while m_tready stays high: the
//   input register hands its byte on in the same cycle that the output register
//   is emptied or taken, and the scan state updates once per byte as it moves
//   on. When the receiver stalls, the output register holds its result and the
//   input register holds at most one more byte; s_tready then drops until
//   m_tready returns. Reset clears both valid flags, puts the scanner outside
//   any list and clears depth, line and column.
module sexpr_token_scanner import sexs_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF,
	parameter int LINE_BITS = LINE_BITS_DEF,
	parameter int COL_BITS  = COL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [7:0] ch
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [3:0] kind, [4] ends_token, [7:5] error_code, [15:8] depth, [16] form_done,
	// [32:17] line, [44:33] column, [47:45] zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam logic [COL_BITS-1:0]  COL_MAX  = '1;
	localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic                 valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;

	mode_t                mode_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [LINE_BITS-1:0] line_q;
	logic [COL_BITS-1:0]  col_q;

	mode_t                mode_next;
	logic [DEPTH_W-1:0]   depth_next;
	scan_flags_t          flags;
	logic [COL_BITS-1:0]  pos_col;
	logic                 load_s2;
	logic                 advance;

	// Handshake: the output register loads when empty or being taken.
	assign load_s2  = !valid_s2 || m_tready;
	assign advance  = valid_s1 && load_s2;
	assign s_tready = !valid_s1 || load_s2;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	// Column of the current byte, saturating.
	assign pos_col = (col_q == COL_MAX) ? col_q : col_q + 1'b1;

	sexs_classify #(
		.MAX_DEPTH (MAX_DEPTH),
		.DEPTH_W   (DEPTH_W)
	) u_classify (
		.ch         (ch_s1),
		.mode       (mode_q),
		.depth      (depth_q),
		.mode_next  (mode_next),
		.depth_next (depth_next),
		.flags      (flags)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1 <= s_tdata;
		end
	end

	// Scan state, updated once per byte as it moves to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_OUT;
			depth_q <= '0;
			line_q  <= '0;
			col_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_next;
			depth_q <= depth_next;
			if (ch_s1 == CH_NL) begin
				col_q <= '0;
				if (line_q != LINE_MAX) begin
					line_q <= line_q + 1'b1;
				end
			end else begin
				col_q <= pos_col;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {3'b000,
			            COL_OUT_W'(pos_col),
			            LINE_OUT_W'(line_q),
			            flags.form_done,
			            DEPTH_OUT_W'(depth_next),
			            flags.error_code,
			            flags.ends_token,
			            flags.kind};
		end
	end

endmodule

### hdl/sexs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the s-expression token scanner, bound to the top level.
// Depends on sexs_pkg and sexpr_token_scanner.
module sexs_checker import sexs_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A completed form always reports depth zero.
	a_done_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> (m_tdata[15:8] == 8'd0))
		else $error("form_done with nonzero depth");

	// Close all always completes the form at depth zero.
	a_close_all: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[3:0] == K_CLOSE_ALL) |->
			m_tdata[16] && (m_tdata[15:8] == 8'd0))
		else $error("close all did not finish the form");

	// A newline-in-string error always ends the string token with a skipped role.
	a_nl_str: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[7:5] == E_NL_IN_STR) |->
			m_tdata[4] && (m_tdata[3:0] == K_SKIP))
		else $error("newline in string not reported as token end");

	// Column is one-based.
	a_col_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[44:33] != 12'd0))
		else $error("column zero reported");

endmodule

bind sexpr_token_scanner sexs_checker u_sexs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### test/tb_sexpr_token_scanner.sv
`timescale 1ns / 1ps
// Self-checking bench for the s-expression token scanner: a directed table, random
// token streams and a depth overflow run, each result checked against a local scanner
// model or, for fixed table rows, typed values. Depends on sexs_pkg and sexpr_token_scanner.
module tb_sexpr_token_scanner;
	import sexs_pkg::*;

	localparam int unsigned DEPTH_CAP   = MAX_DEPTH_DEF;
	localparam int unsigned LINE_CAP    = (1 << LINE_BITS_DEF) - 1;
	localparam int unsigned COL_CAP     = (1 << COL_BITS_DEF) - 1;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          RANDOM_ITEMS = 400;

	// Result item as laid out on m_tdata, lowest field last.
	typedef struct packed {
		logic [2:0]  pad;
		logic [11:0] col;
		logic [15:0] line;
		logic        done;
		logic [7:0]  depth;
		logic [2:0]  err;
		logic        ends;
		logic [3:0]  kind;
	} scan_res_t;

	// One row of the directed table; the result is typed in only where fixed is set.
	typedef struct {
		logic [7:0]  ch;
		bit          fixed;
		kind_t       kind;
		bit          ends;
		err_t        err;
		logic [7:0]  depth;
		bit          done;
		logic [15:0] line;
		logic [11:0] col;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	scan_res_t   pending_results [$];
	int          errors = 0;
	int          cycles = 0;
	int          sent = 0;
	bit          steady = 1'b0;
	bit          mid_drained = 1'b0;
	int          stall_left = 0;

	// Scanner state as the model sees it.
	mode_t       st_mode = M_OUT;
	int unsigned st_depth = 0;
	int unsigned st_line = 0;
	int unsigned st_col = 0;

	plan_row_t plan [25] = '{
		'{8'h78, 1'b1, K_SKIP, 1'b0, E_EXPECT_OPEN, 8'd0, 1'b0, 16'd0, 12'd1},   // 'x' at top
		'{8'h80, 1'b1, K_SKIP, 1'b0, E_EXPECT_OPEN, 8'd0, 1'b0, 16'd0, 12'd2},
		'{CH_SPACE, 1'b1, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd3},
		'{CH_LPAREN, 1'b1, K_OPEN, 1'b0, E_NONE, 8'd1, 1'b0, 16'd0, 12'd4},
		'{8'h61, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},         // 'a'
		'{8'h39, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},         // '9'
		'{CH_RPAREN, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_LPAREN, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_BACKQ, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{8'hFF, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_BACKQ, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_DQUOTE, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{8'h00, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_NL, 1'b1, K_SKIP, 1'b1, E_NL_IN_STR, 8'd1, 1'b0, 16'd0, 12'd14},
		'{CH_SEMI, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_TAB, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_NL, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{8'h23, 1'b1, K_SKIP, 1'b0, E_BAD_LIST, 8'd1, 1'b0, 16'd2, 12'd1},     // '#'
		'{CH_UNDER, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{8'h5A, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},         // 'Z'
		'{CH_RBRACK, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_RPAREN, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_LPAREN, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_LPAREN, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0},
		'{CH_RBRACK, 1'b0, K_SKIP, 1'b0, E_NONE, 8'd0, 1'b0, 16'd0, 12'd0}
	};

	sexpr_token_scanner #(
		.MAX_DEPTH(MAX_DEPTH_DEF),
		.LINE_BITS(LINE_BITS_DEF),
		.COL_BITS (COL_BITS_DEF)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #4 clk = ~clk;

	// Byte classes.
	function automatic bit blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_NL;
	endfunction

	function automatic bit alpha(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic bit word_char(input logic [7:0] b);
		return alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_UNDER;
	endfunction

	// An open paren either nests one deeper or overflows and stays at the cap.
	function automatic void nest_open(inout scan_res_t r);
		r.kind = K_OPEN;
		if (st_depth >= DEPTH_CAP) begin
			st_depth = DEPTH_CAP;
			r.err = E_DEPTH_OVF;
		end else begin
			st_depth++;
		end
		st_mode = M_LIST;
	endfunction

	// Rules for a byte seen inside a list, also used for the byte that ends an identifier.
	function automatic void list_rules(input logic [7:0] b, inout scan_res_t r);
		st_mode = M_LIST;
		if (blank(b)) begin
			r.kind = K_SKIP;
		end else if (alpha(b) || b == CH_UNDER) begin
			r.kind = K_IDENT_START;
			st_mode = M_IDENT;
		end else if (b == CH_BACKQ) begin
			r.kind = K_RAW_QUOTE;
			st_mode = M_RAW;
		end else if (b == CH_DQUOTE) begin
			r.kind = K_STR_QUOTE;
			st_mode = M_STR;
		end else if (b == CH_SEMI) begin
			r.kind = K_CMT_START;
			st_mode = M_CMT;
		end else if (b == CH_LPAREN) begin
			nest_open(r);
		end else if (b == CH_RPAREN) begin
			if (st_depth == 0) begin
				r.kind = K_SKIP;
				r.err = E_BAD_LIST;
				st_mode = M_OUT;
			end else begin
				r.kind = K_CLOSE;
				st_depth--;
				if (st_depth == 0) begin
					r.done = 1'b1;
					st_mode = M_OUT;
				end
			end
		end else if (b == CH_RBRACK) begin
			r.kind = K_CLOSE_ALL;
			st_depth = 0;
			r.done = 1'b1;
			st_mode = M_OUT;
		end else begin
			r.kind = K_SKIP;
			r.err = E_BAD_LIST;
		end
	endfunction

	// Advances the model by one byte and returns the result it should produce.
	function automatic scan_res_t scan_predict(input logic [7:0] b);
		scan_res_t r;
		r = '0;
		if (st_col < COL_CAP)
			st_col++;
		r.line = st_line[15:0];
		r.col = st_col[11:0];
		if (b == CH_NL) begin
			if (st_line < LINE_CAP)
				st_line++;
			st_col = 0;
		end
		case (st_mode)
			M_LIST: list_rules(b, r);
			M_IDENT: begin
				if (word_char(b)) begin
					r.kind = K_IDENT_CONT;
				end else begin
					r.ends = 1'b1;
					list_rules(b, r);
				end
			end
			M_RAW: begin
				if (b == CH_BACKQ) begin
					r.kind = K_RAW_QUOTE;
					r.ends = 1'b1;
					st_mode = M_LIST;
				end else begin
					r.kind = K_RAW_CHAR;
				end
			end
			M_STR: begin
				if (b == CH_DQUOTE) begin
					r.kind = K_STR_QUOTE;
					r.ends = 1'b1;
					st_mode = M_LIST;
				end else if (b == CH_NL) begin
					r.kind = K_SKIP;
					r.ends = 1'b1;
					r.err = E_NL_IN_STR;
					st_mode = M_LIST;
				end else begin
					r.kind = K_STR_CHAR;
				end
			end
			M_CMT: begin
				if (b == CH_NL) begin
					r.kind = K_SKIP;
					r.ends = 1'b1;
					st_mode = M_LIST;
				end else begin
					r.kind = K_CMT_CHAR;
				end
			end
			default: begin
				st_mode = M_OUT;
				if (b == CH_LPAREN)
					nest_open(r);
				else if (!blank(b))
					r.err = E_EXPECT_OPEN;
			end
		endcase
		r.depth = st_depth[7:0];
		return r;
	endfunction

	// Mostly no idling, often a short gap, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] any_except(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == a || c == b);
		return c;
	endfunction

	function automatic logic [7:0] word_pick();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26)
			return 8'h61 + 8'(r);
		if (r < 52)
			return 8'h41 + 8'(r - 26);
		if (r < 62)
			return 8'h30 + 8'(r - 52);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] blank_pick();
		case ($urandom_range(0, 2))
			0: return CH_SPACE;
			1: return CH_TAB;
			default: return CH_NL;
		endcase
	endfunction

	task automatic field_check(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Compares an accepted result with the oldest expectation.
	task automatic take_result(input scan_res_t got);
		scan_res_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result %h, expected none", $time, got);
			errors++;
		end else begin
			want = pending_results.pop_front();
			field_check("kind", 32'(want.kind), 32'(got.kind));
			field_check("ends_token", 32'(want.ends), 32'(got.ends));
			field_check("error_code", 32'(want.err), 32'(got.err));
			field_check("depth", 32'(want.depth), 32'(got.depth));
			field_check("form_done", 32'(want.done), 32'(got.done));
			field_check("line", 32'(want.line), 32'(got.line));
			field_check("column", 32'(want.col), 32'(got.col));
			field_check("padding", 32'(want.pad), 32'(got.pad));
		end
	endtask

	// Presents one byte and holds it until the scanner takes it.
	task automatic send_byte(input logic [7:0] b, input bit fixed, input scan_res_t typed);
		scan_res_t want;
		int n;
		want = scan_predict(b);
		pending_results.push_back(fixed ? typed : want);
		sent++;
		n = steady ? 0 : idle_len();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send(input logic [7:0] b);
		send_byte(b, 1'b0, '0);
	endtask

	// Stops sending until every outstanding result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Closes whatever token and lists are open so the scanner is back at top level.
	task automatic back_to_top();
		case (st_mode)
			M_RAW: send(CH_BACKQ);
			M_STR: send(CH_DQUOTE);
			M_CMT: send(CH_NL);
			default: ;
		endcase
		if (st_mode != M_OUT)
			send(CH_RBRACK);
	endtask

	// One random token: mostly well-formed, sometimes a stray byte.
	task automatic random_chunk();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			send(8'($urandom_range(0, 255)));
		end else if (st_mode == M_OUT) begin
			send(r < 85 ? CH_LPAREN : blank_pick());
		end else begin
			r = $urandom_range(0, 99);
			if (r < 22) begin
				send(CH_LPAREN);
			end else if (r < 42) begin
				send(CH_RPAREN);
			end else if (r < 60) begin
				send($urandom_range(0, 9) == 0 ? CH_UNDER : word_pick() | 8'h40);
				n = $urandom_range(0, 6);
				repeat (n) send(word_pick());
			end else if (r < 68) begin
				send(CH_BACKQ);
				n = $urandom_range(0, 8);
				repeat (n) send(any_except(CH_BACKQ, CH_BACKQ));
				send(CH_BACKQ);
			end else if (r < 76) begin
				send(CH_DQUOTE);
				n = $urandom_range(0, 8);
				repeat (n) send(any_except(CH_DQUOTE, CH_NL));
				send($urandom_range(0, 9) == 0 ? CH_NL : CH_DQUOTE);
			end else if (r < 82) begin
				send(CH_SEMI);
				n = $urandom_range(0, 10);
				repeat (n) send(any_except(CH_NL, CH_NL));
				send(CH_NL);
			end else if (r < 95) begin
				send(blank_pick());
			end else begin
				send(CH_RBRACK);
			end
		end
	endtask

	// Receiver: checks each accepted result, then decides whether to stall.
	always @(posedge clk) begin
		int n;
		if (m_tvalid && m_tready)
			take_result(m_tdata);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			n = steady ? 0 : idle_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				stall_left = n - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		scan_res_t typed;
		int start;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (plan[i]) begin
			typed = '0;
			typed.kind = plan[i].kind;
			typed.ends = plan[i].ends;
			typed.err = plan[i].err;
			typed.depth = plan[i].depth;
			typed.done = plan[i].done;
			typed.line = plan[i].line;
			typed.col = plan[i].col;
			send_byte(plan[i].ch, plan[i].fixed, typed);
		end
		drain();

		// Random token streams, with a full drain halfway.
		start = sent;
		while (sent - start < RANDOM_ITEMS) begin
			if ((sent - start) % 100 < 3)
				steady = ($urandom_range(0, 3) == 0);
			if (!mid_drained && sent - start >= RANDOM_ITEMS / 2) begin
				drain();
				mid_drained = 1'b1;
			end
			random_chunk();
		end
		steady = 1'b0;

		// Depth overflow: open past the cap, close a few, then close all.
		back_to_top();
		repeat (DEPTH_CAP + 3) send(CH_LPAREN);
		repeat (3) send(CH_RPAREN);
		send(CH_RBRACK);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
